// ----- rtl/ddc_get_feature_reply_parser_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the get-feature reply parser
// Implication checks sampled on the rising clock, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef DDC_GET_FEATURE_REPLY_PARSER_UNIT_ASSERT_SVH
`define DDC_GET_FEATURE_REPLY_PARSER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define DGFR_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
`define DGFR_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define DGFR_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons)
`define DGFR_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)
`endif

`endif

// ----- rtl/ddc_gfr_pkg.sv -----
// ----------------------------------------------------------------------------
// ddc_gfr_pkg
// Types and constants of the get-feature reply parser.
// ----------------------------------------------------------------------------
package ddc_gfr_pkg;

	localparam logic [7:0] LEN_MASK    = 8'h7F;
	localparam int         KEEP_BYTES  = 8;
	localparam int         KEEP_IDX_W  = $clog2(KEEP_BYTES);
	localparam logic [7:0] FRAME_EXTRA = 8'd3;
	localparam logic [7:0] COUNT_MAX   = 8'hFF;
	localparam logic [7:0] RC_OK       = 8'h00;

	localparam logic [7:0] RESET_SOURCE_ADDRESS   = 8'h6E;
	localparam logic [7:0] RESET_CHECKSUM_SEED    = 8'h50;
	localparam logic [7:0] RESET_REPLY_COMMAND    = 8'h02;
	localparam logic [7:0] RESET_UNSUPPORTED_CODE = 8'h01;

	localparam logic [1:0] CFG_SOURCE_ADDRESS   = 2'd0;
	localparam logic [1:0] CFG_CHECKSUM_SEED    = 2'd1;
	localparam logic [1:0] CFG_REPLY_COMMAND    = 2'd2;
	localparam logic [1:0] CFG_UNSUPPORTED_CODE = 2'd3;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_PARSE       = 3'd1,
		ST_CHECKSUM    = 3'd2,
		ST_NULL        = 3'd3,
		ST_UNSUPPORTED = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       last_byte;
		logic [7:0] expected_feature;
	} in_word_t;

	typedef struct packed {
		logic    present;
		status_t status;
	} out_user_t;

	typedef struct packed {
		logic [15:0] current_value;
		logic [15:0] maximum_value;
		logic [7:0]  feature_type;
	} out_data_t;

endpackage

// ----- rtl/ddc_get_feature_reply_parser_unit.sv -----
// ----------------------------------------------------------------------------
// ddc_get_feature_reply_parser_unit
// Parses a get-feature reply one byte per word and reports one result word
// on the last byte of each buffer.
// m_tvalid rises when the last byte moves from the input register into the
// result register. One byte per cycle, but a last byte waits in stage 1 while
// the result register holds an unaccepted result. The input and result
// registers are the only stages; frame state updates as bytes leave stage 1.
// Reset: arst_n clears frame state, handshake state and restores registers.
// ----------------------------------------------------------------------------
`include "ddc_get_feature_reply_parser_unit_assert.svh"

module ddc_get_feature_reply_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // rx_byte[7:0], expected_feature[15:8]
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // feature_type[7:0], maximum_value[23:8],
	                               // current_value[39:24]
	output logic [3:0]  m_tuser    // status[2:0], present[3]
);

	logic [7:0] source_address_q;
	logic [7:0] checksum_seed_q;
	logic [7:0] reply_command_q;
	logic [7:0] unsupported_code_q;

	logic                 valid_s1;
	ddc_gfr_pkg::in_word_t word_s1;

	logic [7:0] byte_count_q;
	logic [7:0] running_xor_q;
	logic [6:0] declared_length_q;
	logic       header_bad_q;
	logic [7:0] frame_xor_q;
	logic [7:0] held_feature_q;
	logic [7:0] payload_q [ddc_gfr_pkg::KEEP_BYTES];

	logic                   out_valid_q;
	ddc_gfr_pkg::out_user_t out_user_q;
	ddc_gfr_pkg::out_data_t out_data_q;

	logic out_free;
	logic adv_s1;
	logic in_fire;

	logic [7:0] byte_count_n;
	logic [7:0] running_xor_n;
	logic [6:0] declared_length_n;
	logic       header_bad_n;
	logic [7:0] frame_xor_n;
	logic [7:0] held_feature_n;
	logic       pay_we;
	logic [ddc_gfr_pkg::KEEP_IDX_W-1:0] pay_idx;
	logic [7:0] pay_n [ddc_gfr_pkg::KEEP_BYTES];

	ddc_gfr_pkg::out_user_t res_user;
	ddc_gfr_pkg::out_data_t res_data;

	assign out_free = !out_valid_q || m_tready;
	assign adv_s1   = valid_s1 && (!word_s1.last_byte || out_free);
	assign s_tready = !valid_s1 || adv_s1;
	assign in_fire  = s_tvalid && s_tready;

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_user_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_address_q   <= ddc_gfr_pkg::RESET_SOURCE_ADDRESS;
			checksum_seed_q    <= ddc_gfr_pkg::RESET_CHECKSUM_SEED;
			reply_command_q    <= ddc_gfr_pkg::RESET_REPLY_COMMAND;
			unsupported_code_q <= ddc_gfr_pkg::RESET_UNSUPPORTED_CODE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ddc_gfr_pkg::CFG_SOURCE_ADDRESS:   source_address_q   <= cfg_data;
				ddc_gfr_pkg::CFG_CHECKSUM_SEED:    checksum_seed_q    <= cfg_data;
				ddc_gfr_pkg::CFG_REPLY_COMMAND:    reply_command_q    <= cfg_data;
				ddc_gfr_pkg::CFG_UNSUPPORTED_CODE: unsupported_code_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			word_s1.rx_byte          <= s_tdata[7:0];
			word_s1.expected_feature <= s_tdata[15:8];
			word_s1.last_byte        <= s_tlast;
		end
	end

	// Frame state after taking the byte in stage 1.
	always_comb begin
		logic [7:0] idx;
		logic [7:0] b;
		logic [7:0] need;
		logic [7:0] off;
		idx               = byte_count_q;
		b                 = word_s1.rx_byte;
		need              = {1'b0, declared_length_q} + ddc_gfr_pkg::FRAME_EXTRA;
		off               = idx - 8'd2;
		byte_count_n      = byte_count_q;
		running_xor_n     = running_xor_q;
		declared_length_n = declared_length_q;
		header_bad_n      = header_bad_q;
		frame_xor_n       = frame_xor_q;
		held_feature_n    = held_feature_q;
		pay_we            = 1'b0;
		pay_idx           = off[ddc_gfr_pkg::KEEP_IDX_W-1:0];
		if (idx != ddc_gfr_pkg::COUNT_MAX) begin
			byte_count_n = idx + 8'd1;
			if (idx == 8'd0) begin
				held_feature_n = word_s1.expected_feature;
				running_xor_n  = checksum_seed_q ^ b;
				if (b != source_address_q) begin
					header_bad_n = 1'b1;
				end
			end else if (idx == 8'd1) begin
				running_xor_n     = running_xor_q ^ b;
				declared_length_n = 7'(b & ddc_gfr_pkg::LEN_MASK);
				if (!b[7]) begin
					header_bad_n = 1'b1;
				end
				if (b[6:0] == 7'd0) begin
					frame_xor_n = running_xor_q ^ b;
				end
			end else if (idx < need) begin
				running_xor_n = running_xor_q ^ b;
				pay_we        = off < 8'(ddc_gfr_pkg::KEEP_BYTES);
				if (idx == need - 8'd1) begin
					frame_xor_n = running_xor_q ^ b;
				end
			end
		end
		for (int i = 0; i < ddc_gfr_pkg::KEEP_BYTES; i++) begin
			pay_n[i] = (pay_we && pay_idx == ddc_gfr_pkg::KEEP_IDX_W'(i)) ? b : payload_q[i];
		end
	end

	// Judge the buffer on its last byte.
	always_comb begin
		logic [7:0] need_n;
		need_n           = {1'b0, declared_length_n} + ddc_gfr_pkg::FRAME_EXTRA;
		res_user.status  = ddc_gfr_pkg::ST_PARSE;
		res_data         = '0;
		if (byte_count_n < ddc_gfr_pkg::FRAME_EXTRA || header_bad_n) begin
			res_user.status = ddc_gfr_pkg::ST_PARSE;
		end else if (need_n > byte_count_n) begin
			res_user.status = ddc_gfr_pkg::ST_PARSE;
		end else if (frame_xor_n != 8'd0) begin
			res_user.status = ddc_gfr_pkg::ST_CHECKSUM;
		end else if (declared_length_n == 7'd0) begin
			res_user.status = ddc_gfr_pkg::ST_NULL;
		end else if (pay_n[0] != reply_command_q) begin
			res_user.status = ddc_gfr_pkg::ST_PARSE;
		end else if (declared_length_n >= 7'd2 && pay_n[1] == unsupported_code_q) begin
			if (declared_length_n >= 7'd3 && pay_n[2] != held_feature_n) begin
				res_user.status = ddc_gfr_pkg::ST_PARSE;
			end else begin
				res_user.status = ddc_gfr_pkg::ST_UNSUPPORTED;
			end
		end else if (declared_length_n < 7'(ddc_gfr_pkg::KEEP_BYTES)
				|| pay_n[1] != ddc_gfr_pkg::RC_OK || pay_n[2] != held_feature_n) begin
			res_user.status = ddc_gfr_pkg::ST_PARSE;
		end else begin
			res_user.status        = ddc_gfr_pkg::ST_OK;
			res_data.feature_type  = pay_n[3];
			res_data.maximum_value = {pay_n[4], pay_n[5]};
			res_data.current_value = {pay_n[6], pay_n[7]};
		end
		res_user.present = res_user.status == ddc_gfr_pkg::ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q      <= '0;
			running_xor_q     <= '0;
			declared_length_q <= '0;
			header_bad_q      <= 1'b0;
			frame_xor_q       <= '0;
			held_feature_q    <= '0;
		end else if (adv_s1) begin
			if (word_s1.last_byte) begin
				byte_count_q      <= '0;
				running_xor_q     <= '0;
				declared_length_q <= '0;
				header_bad_q      <= 1'b0;
				frame_xor_q       <= '0;
				held_feature_q    <= '0;
			end else begin
				byte_count_q      <= byte_count_n;
				running_xor_q     <= running_xor_n;
				declared_length_q <= declared_length_n;
				header_bad_q      <= header_bad_n;
				frame_xor_q       <= frame_xor_n;
				held_feature_q    <= held_feature_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && pay_we) begin
			payload_q[pay_idx] <= word_s1.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && word_s1.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && word_s1.last_byte) begin
			out_user_q <= res_user;
			out_data_q <= res_data;
		end
	end

	`DGFR_ASSERT_SAME(a_zero_unless_ok, clk, arst_n,
		m_tvalid && m_tuser[2:0] != ddc_gfr_pkg::ST_OK, m_tdata == 40'd0 && !m_tuser[3])
	`DGFR_ASSERT_SAME(a_no_overwrite, clk, arst_n,
		valid_s1 && word_s1.last_byte && out_valid_q && !m_tready, !s_tready)
	`DGFR_ASSERT_NEXT(a_rearm, clk, arst_n,
		adv_s1 && word_s1.last_byte, byte_count_q == 8'd0)
	`DGFR_ASSERT_NEXT(a_saturate, clk, arst_n,
		adv_s1 && !word_s1.last_byte && byte_count_q == ddc_gfr_pkg::COUNT_MAX,
		byte_count_q == ddc_gfr_pkg::COUNT_MAX)

endmodule

// ----- tb/ddc_get_feature_reply_parser_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddc_get_feature_reply_parser_unit_test
// Drives get-feature reply buffers into the parser one byte per word and
// compares every reply word with the reply given in its table row or, failing
// that, a behavioral prediction. A short table of hand-built buffers runs
// first. Random buffers follow over several register settings: mostly
// well-formed frames with random content, plus truncated, corrupted, long and
// noise buffers. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module ddc_get_feature_reply_parser_unit_test;

	localparam int PHASE_WORDS = 160;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		ddc_gfr_pkg::status_t status;
		logic        present;
		logic [7:0]  ftype;
		logic [15:0] maxv;
		logic [15:0] curv;
	} reply_t;

	typedef struct packed {
		logic [7:0] rx;
		logic       last;
		logic [7:0] feat;
		logic       typed;
		reply_t     want;
	} row_t;

	localparam reply_t R_NONE  = '{ddc_gfr_pkg::ST_OK, 1'b0, 8'h00, 16'h0000, 16'h0000};
	localparam reply_t R_PARSE = '{ddc_gfr_pkg::ST_PARSE, 1'b0, 8'h00, 16'h0000, 16'h0000};
	localparam reply_t R_CSUM  = '{ddc_gfr_pkg::ST_CHECKSUM, 1'b0, 8'h00, 16'h0000, 16'h0000};
	localparam reply_t R_NULL  = '{ddc_gfr_pkg::ST_NULL, 1'b0, 8'h00, 16'h0000, 16'h0000};
	localparam reply_t R_UNSUP = '{ddc_gfr_pkg::ST_UNSUPPORTED, 1'b0, 8'h00, 16'h0000,
		16'h0000};
	localparam reply_t R_GOOD  = '{ddc_gfr_pkg::ST_OK, 1'b1, 8'hFF, 16'hFFFF, 16'h0000};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = ddc_gfr_pkg::CFG_SOURCE_ADDRESS;
	logic [7:0]  cfg_data = 8'h00;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = 16'h0000;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [3:0]  m_tuser;

	ddc_get_feature_reply_parser_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// register copies and frame state of the parser
	logic [7:0] cfg_src   = ddc_gfr_pkg::RESET_SOURCE_ADDRESS;
	logic [7:0] cfg_seed  = ddc_gfr_pkg::RESET_CHECKSUM_SEED;
	logic [7:0] cfg_cmd   = ddc_gfr_pkg::RESET_REPLY_COMMAND;
	logic [7:0] cfg_unsup = ddc_gfr_pkg::RESET_UNSUPPORTED_CODE;

	logic [7:0] seen_cnt = 8'h00;
	logic [7:0] run_xor = 8'h00;
	logic [6:0] decl_len = 7'h00;
	logic       hdr_bad = 1'b0;
	logic [7:0] latched_xor = 8'h00;
	logic [7:0] kept [ddc_gfr_pkg::KEEP_BYTES] = '{default: 8'h00};
	logic [7:0] feat_held = 8'h00;

	reply_t     replies_due [$];
	reply_t     predicted;
	reply_t     want;
	logic       row_typed = 1'b0;
	reply_t     row_want = R_NONE;
	ddc_gfr_pkg::out_user_t got_user;
	ddc_gfr_pkg::out_data_t got_data;

	int idle_pct = 26;
	int hold_trigger = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int stall_run = 0;
	int errors = 0;
	int words_sent = 0;
	int buffers_sent = 0;
	int replies_checked = 0;
	int settings_used = 1;
	int status_tally [5] = '{default: 0};

	assign got_user = m_tuser;
	assign got_data = m_tdata;

	function automatic void restart_frame();
		seen_cnt = 8'h00;
		run_xor = 8'h00;
		decl_len = 7'h00;
		hdr_bad = 1'b0;
		latched_xor = 8'h00;
		feat_held = 8'h00;
		for (int i = 0; i < ddc_gfr_pkg::KEEP_BYTES; i++)
			kept[i] = 8'h00;
	endfunction

	function automatic void absorb_byte(input logic [7:0] b, input logic [7:0] f);
		int pos;
		int need;
		pos = seen_cnt;
		if (seen_cnt == ddc_gfr_pkg::COUNT_MAX)
			return;
		seen_cnt = seen_cnt + 8'd1;
		if (pos == 0) begin
			feat_held = f;
			run_xor = cfg_seed ^ b;
			if (b != cfg_src)
				hdr_bad = 1'b1;
		end else if (pos == 1) begin
			run_xor = run_xor ^ b;
			decl_len = 7'(b & ddc_gfr_pkg::LEN_MASK);
			if (!b[7])
				hdr_bad = 1'b1;
			if (decl_len == 7'd0)
				latched_xor = run_xor;
		end else begin
			need = int'(decl_len) + int'(ddc_gfr_pkg::FRAME_EXTRA);
			if (pos < need) begin
				run_xor = run_xor ^ b;
				if (pos - 2 < ddc_gfr_pkg::KEEP_BYTES)
					kept[pos - 2] = b;
				if (pos == need - 1)
					latched_xor = run_xor;
			end
		end
	endfunction

	function automatic reply_t judge_reply();
		reply_t r;
		r = R_PARSE;
		if (seen_cnt < 8'd3 || hdr_bad)
			r.status = ddc_gfr_pkg::ST_PARSE;
		else if (int'(decl_len) + int'(ddc_gfr_pkg::FRAME_EXTRA) > int'(seen_cnt))
			r.status = ddc_gfr_pkg::ST_PARSE;
		else if (latched_xor != 8'h00)
			r.status = ddc_gfr_pkg::ST_CHECKSUM;
		else if (decl_len == 7'd0)
			r.status = ddc_gfr_pkg::ST_NULL;
		else if (kept[0] != cfg_cmd)
			r.status = ddc_gfr_pkg::ST_PARSE;
		else if (decl_len >= 7'd2 && kept[1] == cfg_unsup)
			r.status = (decl_len >= 7'd3 && kept[2] != feat_held) ?
				ddc_gfr_pkg::ST_PARSE : ddc_gfr_pkg::ST_UNSUPPORTED;
		else if (decl_len < 7'd8 || kept[1] != ddc_gfr_pkg::RC_OK || kept[2] != feat_held)
			r.status = ddc_gfr_pkg::ST_PARSE;
		else begin
			r.status = ddc_gfr_pkg::ST_OK;
			r.present = 1'b1;
			r.ftype = kept[3];
			r.maxv = {kept[4], kept[5]};
			r.curv = {kept[6], kept[7]};
		end
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			absorb_byte(s_tdata[7:0], s_tdata[15:8]);
			if (s_tlast) begin
				predicted = judge_reply();
				replies_due.push_back(row_typed ? row_want : predicted);
				restart_frame();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (replies_due.size() == 0) begin
				$display("%0t: reply word with none expected, got status %0d", $time,
					got_user.status);
				errors++;
			end else begin
				want = replies_due.pop_front();
				replies_checked++;
				status_tally[want.status]++;
				if (got_user.status !== want.status) begin
					$display("%0t: status expected %0d, got %0d", $time, want.status,
						got_user.status);
					errors++;
				end
				if (got_user.present !== want.present) begin
					$display("%0t: present expected %0b, got %0b", $time, want.present,
						got_user.present);
					errors++;
				end
				if (got_data.feature_type !== want.ftype) begin
					$display("%0t: feature_type expected %h, got %h", $time, want.ftype,
						got_data.feature_type);
					errors++;
				end
				if (got_data.maximum_value !== want.maxv) begin
					$display("%0t: maximum_value expected %h, got %h", $time, want.maxv,
						got_data.maximum_value);
					errors++;
				end
				if (got_data.current_value !== want.curv) begin
					$display("%0t: current_value expected %h, got %h", $time, want.curv,
						got_data.current_value);
					errors++;
				end
			end
		end
		if (hold_trigger != hold_seen) begin
			hold_seen <= hold_trigger;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_run <= 0;
			else
				stall_run <= stall_run + 1;
			if (stall_run >= STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
				$display("ddc_get_feature_reply_parser_unit: mismatch");
				$finish;
			end
		end
	end

	task automatic push_word(input row_t r);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {r.feat, r.rx};
		s_tlast <= r.last;
		row_typed <= r.typed;
		row_want <= r.want;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		words_sent++;
		if (r.last)
			buffers_sent++;
	endtask

	task automatic send_buffer(input logic [7:0] fq [$], input logic [7:0] feat);
		row_t r;
		for (int i = 0; i < fq.size(); i++) begin
			r.rx = fq[i];
			r.last = (i == fq.size() - 1);
			r.feat = (i == 0) ? feat : 8'($urandom);
			r.typed = 1'b0;
			r.want = R_NONE;
			push_word(r);
		end
	endtask

	task automatic send_random_buffer();
		logic [7:0] fq [$];
		logic [7:0] feat;
		logic [7:0] x;
		int kind;
		int len;
		int n;
		int i;
		feat = 8'($urandom);
		kind = $urandom_range(99);
		if (kind < 75) begin
			n = $urandom_range(99);
			if (n < 10)
				len = 0;
			else if (n < 22)
				len = $urandom_range(1, 7);
			else if (n < 85)
				len = 8;
			else if (n < 95)
				len = $urandom_range(9, 20);
			else
				len = $urandom_range(21, 127);
			fq.push_back(cfg_src);
			fq.push_back(8'h80 | 8'(len));
			for (i = 0; i < len; i++) begin
				case (i)
				0: x = ($urandom_range(9) != 0) ? cfg_cmd : 8'($urandom);
				1: begin
					n = $urandom_range(9);
					x = (n < 4) ? ddc_gfr_pkg::RC_OK : (n < 7) ? cfg_unsup : 8'($urandom);
				end
				2: x = ($urandom_range(9) < 8) ? feat : 8'($urandom);
				default: x = 8'($urandom);
				endcase
				fq.push_back(x);
			end
			x = cfg_seed;
			foreach (fq[j])
				x = x ^ fq[j];
			fq.push_back(($urandom_range(9) != 0) ? x : 8'($urandom));
			if ($urandom_range(9) < 2)
				repeat ($urandom_range(1, 3))
					fq.push_back(8'($urandom));
			if ($urandom_range(9) == 0) begin
				n = $urandom_range(1, fq.size() - 1);
				while (fq.size() > n)
					void'(fq.pop_back());
			end
		end else if (kind < 87) begin
			fq.push_back($urandom_range(1) ? cfg_src : 8'($urandom));
			fq.push_back(8'($urandom));
			repeat ($urandom_range(0, 10))
				fq.push_back(8'($urandom));
		end else begin
			repeat ($urandom_range(1, 12))
				fq.push_back(8'($urandom));
		end
		send_buffer(fq, feat);
	endtask

	task automatic write_regs(input logic [7:0] src, input logic [7:0] seed,
		input logic [7:0] cmd, input logic [7:0] unsup);
		cfg_we <= 1'b1;
		cfg_index <= ddc_gfr_pkg::CFG_SOURCE_ADDRESS;
		cfg_data <= src;
		@(posedge clk);
		cfg_index <= ddc_gfr_pkg::CFG_CHECKSUM_SEED;
		cfg_data <= seed;
		@(posedge clk);
		cfg_index <= ddc_gfr_pkg::CFG_REPLY_COMMAND;
		cfg_data <= cmd;
		@(posedge clk);
		cfg_index <= ddc_gfr_pkg::CFG_UNSUPPORTED_CODE;
		cfg_data <= unsup;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_src = src;
		cfg_seed = seed;
		cfg_cmd = cmd;
		cfg_unsup = unsup;
		settings_used++;
	endtask

	row_t directed_rows [29] = '{
		'{8'h6E, 1'b1, 8'h00, 1'b1, R_PARSE},
		'{8'h00, 1'b0, 8'hFF, 1'b0, R_NONE},
		'{8'h7F, 1'b0, 8'h00, 1'b0, R_NONE},
		'{8'h00, 1'b1, 8'h00, 1'b1, R_PARSE},
		'{8'h6E, 1'b0, 8'h5A, 1'b0, R_NONE},
		'{8'h80, 1'b0, 8'h00, 1'b0, R_NONE},
		'{8'hBE, 1'b1, 8'h00, 1'b1, R_NULL},
		'{8'h6E, 1'b0, 8'h10, 1'b0, R_NONE},
		'{8'h88, 1'b0, 8'hFF, 1'b0, R_NONE},
		'{8'h02, 1'b0, 8'h00, 1'b0, R_NONE},
		'{8'h00, 1'b0, 8'hFF, 1'b0, R_NONE},
		'{8'h10, 1'b0, 8'h00, 1'b0, R_NONE},
		'{8'hFF, 1'b0, 8'hFF, 1'b0, R_NONE},
		'{8'hFF, 1'b0, 8'h00, 1'b0, R_NONE},
		'{8'hFF, 1'b0, 8'hFF, 1'b0, R_NONE},
		'{8'h00, 1'b0, 8'h00, 1'b0, R_NONE},
		'{8'h00, 1'b0, 8'hFF, 1'b0, R_NONE},
		'{8'h5B, 1'b1, 8'h00, 1'b1, R_GOOD},
		'{8'h6E, 1'b0, 8'hFF, 1'b0, R_NONE},
		'{8'h80, 1'b0, 8'h00, 1'b0, R_NONE},
		'{8'h00, 1'b1, 8'hFF, 1'b1, R_CSUM},
		'{8'h6E, 1'b0, 8'h3C, 1'b0, R_NONE},
		'{8'h85, 1'b0, 8'h00, 1'b0, R_NONE},
		'{8'h02, 1'b1, 8'h00, 1'b1, R_PARSE},
		'{8'h6E, 1'b0, 8'h77, 1'b0, R_NONE},
		'{8'h82, 1'b0, 8'h00, 1'b0, R_NONE},
		'{8'h02, 1'b0, 8'h00, 1'b0, R_NONE},
		'{8'h01, 1'b0, 8'h00, 1'b0, R_NONE},
		'{8'hBF, 1'b1, 8'h00, 1'b0, R_NONE}
	};

	initial begin
		logic [7:0] long_q [$];
		int phase_start;
		bit paused;
		paused = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			push_word(directed_rows[i]);

		for (int p = 0; p < 5; p++) begin
			s_tvalid <= 1'b0;
			wait (replies_due.size() == 0);
			repeat (4) @(posedge clk);
			case (p)
			0: write_regs(8'h00, 8'h00, 8'h00, 8'h00);
			1: write_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF);
			default: write_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
			endcase
			idle_pct = (p == 3) ? 0 : 26;
			if (p == 1)
				hold_trigger <= hold_trigger + 1;
			phase_start = words_sent;
			if (p == 2) begin
				long_q = '{cfg_src, 8'hFF};
				repeat (254 + $urandom_range(0, 24))
					long_q.push_back(8'($urandom));
				send_buffer(long_q, 8'($urandom));
			end
			while (words_sent - phase_start < PHASE_WORDS) begin
				send_random_buffer();
				if (p == 4 && !paused && words_sent - phase_start > PHASE_WORDS / 2) begin
					s_tvalid <= 1'b0;
					wait (replies_due.size() == 0);
					@(posedge clk);
					paused = 1'b1;
				end
			end
		end

		s_tvalid <= 1'b0;
		wait (replies_due.size() == 0);
		repeat (8) @(posedge clk);
		$display("%0d bytes in %0d buffers over %0d register settings, %0d replies checked",
			words_sent, buffers_sent, settings_used, replies_checked);
		$display("replies by status: ok %0d, parse %0d, checksum %0d, null %0d, unsupported %0d",
			status_tally[0], status_tally[1], status_tally[2], status_tally[3], status_tally[4]);
		if (errors == 0)
			$display("ddc_get_feature_reply_parser_unit: match");
		else
			$display("ddc_get_feature_reply_parser_unit: mismatch");
		$finish;
	end

endmodule
